@@ src/lrj_pkg.sv @@
// Shared types and codes for the LCG rewind/jump block.
// No dependencies; every other file of the block except lrj_count refers to this package.
`default_nettype none

package lrj_pkg;

  // Request type codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_REWIND = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MULT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INCR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOD  = 2'd2;

  // Serial arithmetic unit operations
  typedef enum logic {
    SU_DIV,
    SU_MUL
  } su_op_t;

  typedef struct packed {
    logic   start;
    su_op_t op;
  } su_cmd_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED,
    S_COUNT,
    S_RA,
    S_EU_CHK,
    S_EU_DIV,
    S_EU_MUL,
    S_B_RED,
    S_B_MUL,
    S_X_RED,
    S_J_CHK,
    S_J_MX,
    S_J_MB,
    S_J_MA,
    S_FINISH
  } lrj_state_t;

endpackage

`default_nettype wire

@@ src/lrj_if.sv @@
// Handshake channels of the LCG rewind/jump block: request, response, config.
// Uses lrj_pkg for the register index width.
`default_nettype none

interface lrj_req_if #(parameter int VALUE_WIDTH = 31);
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [VALUE_WIDTH-1:0] seed_value;
  logic [VALUE_WIDTH-1:0] step_a;
  logic [VALUE_WIDTH-1:0] step_b;
  modport source (output valid, req_type, seed_value, step_a, step_b, input ready);
  modport sink   (input valid, req_type, seed_value, step_a, step_b, output ready);
endinterface

interface lrj_rsp_if #(parameter int VALUE_WIDTH = 31);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] state_value;
  logic                   rewind_error;
  modport source (output valid, state_value, rewind_error, input ready);
  modport sink   (input valid, state_value, rewind_error, output ready);
endinterface

interface lrj_cfg_if #(parameter int VALUE_WIDTH = 31);
  logic                            valid;
  logic                            ready;
  logic [lrj_pkg::CFG_IDX_W-1:0]   index;
  logic [VALUE_WIDTH-1:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/lcg_rewind_jump.sv @@
// Top level of the LCG rewind/jump block: controller, registers, state.
// Depends on lrj_pkg, lrj_if, lrj_serial and lrj_count.
//
//   port   dir   word carries
//   req    in    req_type, seed_value, step_a, step_b
//   rsp    out   state_value, rewind_error
//   cfg    in    index, data (multiplier, increment, modulus)
//
// A load runs one serial reduction from accept to response. A rewind forms
// the step count, reduces the state, and then runs up to three serial
// multiplications per bit of the count up to its top set bit (at most 2*W
// bits, W = VALUE_WIDTH). The first rewind after a register write adds the
// inverse derivation: a division and a multiplication per Euclid round and
// three more serial operations. The serial operations share the one unit.
// Reset (synchronous) clears the state to zero and the registers to defaults.
// A held response blocks only the finish of the next word, not its accept.
`default_nettype none

module lcg_rewind_jump #(
  parameter int VALUE_WIDTH = 31
) (
  input wire clk,
  input wire rst,
  lrj_req_if.sink   req,
  lrj_rsp_if.source rsp,
  lrj_cfg_if.sink   cfg
);

  localparam int W = VALUE_WIDTH;
  localparam logic [W-1:0] MULT_RST = W'(16807);
  localparam logic [W-1:0] MOD_RST  = W'(2147483647);

  lrj_pkg::lrj_state_t state, state_next;

  logic [W-1:0]   multiplier, increment, modulus;
  logic [W-1:0]   m;
  logic [W-1:0]   cur, ai, bi;
  logic           inv_ready;
  logic           rtype;
  logic [W-1:0]   seed, sa, sb;
  logic           err;
  logic [W-1:0]   ra, rb, rr, q, cu, cs;
  logic [W-1:0]   x, ma, mb;
  logic [2*W-1:0] cnt;
  logic           launched;

  lrj_pkg::su_cmd_t su_cmd;
  logic [W-1:0]     su_a, su_b, su_quo, su_rem;
  logic             su_done;
  logic             cnt_start, cnt_done;
  logic [2*W-1:0]   product;

  logic [W:0]   sum_xm;
  logic [W-1:0] x_add;
  logic [W-1:0] cu_sub;
  logic [W-1:0] neg_t;
  logic [W:0]   ma_inc;
  logic [W-1:0] ma1;
  logic         accept;

  assign m = (modulus == '0) ? W'(1) : modulus;
  assign accept = req.valid && req.ready;

  lrj_serial #(.VALUE_WIDTH(W)) u_serial (
    .clk(clk), .rst(rst), .cmd(su_cmd), .opa(su_a), .opb(su_b),
    .modulus(m), .done(su_done), .quo(su_quo), .rem(su_rem)
  );

  lrj_count #(.VALUE_WIDTH(W)) u_count (
    .clk(clk), .rst(rst), .start(cnt_start), .fa(sa), .fb(sb),
    .done(cnt_done), .product(product)
  );

  // Modular add, subtract and negate on residues below m
  always_comb begin
    sum_xm = {1'b0, su_rem} + {1'b0, mb};
    x_add  = (sum_xm >= {1'b0, m}) ? W'(sum_xm - {1'b0, m}) : sum_xm[W-1:0];
    cu_sub = (cu >= su_rem) ? (cu - su_rem) : (cu + m - su_rem);
    neg_t  = (su_rem == '0) ? '0 : (m - su_rem);
    ma_inc = {1'b0, ma} + 1'b1;
    ma1    = (ma_inc == {1'b0, m}) ? '0 : ma_inc[W-1:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lrj_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (req.req_type == lrj_pkg::REQ_LOAD) ? lrj_pkg::S_SEED
                                                           : lrj_pkg::S_COUNT;
        end
      end
      lrj_pkg::S_SEED:   if (su_done) state_next = lrj_pkg::S_FINISH;
      lrj_pkg::S_COUNT: begin
        if (cnt_done) begin
          state_next = inv_ready ? lrj_pkg::S_X_RED : lrj_pkg::S_RA;
        end
      end
      lrj_pkg::S_RA:     if (su_done) state_next = lrj_pkg::S_EU_CHK;
      lrj_pkg::S_EU_CHK: begin
        priority if (rb != '0) state_next = lrj_pkg::S_EU_DIV;
        else if (ra == W'(1))  state_next = lrj_pkg::S_B_RED;
        else                   state_next = lrj_pkg::S_FINISH;
      end
      lrj_pkg::S_EU_DIV: if (su_done) state_next = lrj_pkg::S_EU_MUL;
      lrj_pkg::S_EU_MUL: if (su_done) state_next = lrj_pkg::S_EU_CHK;
      lrj_pkg::S_B_RED:  if (su_done) state_next = lrj_pkg::S_B_MUL;
      lrj_pkg::S_B_MUL:  if (su_done) state_next = lrj_pkg::S_X_RED;
      lrj_pkg::S_X_RED:  if (su_done) state_next = lrj_pkg::S_J_CHK;
      lrj_pkg::S_J_CHK: begin
        priority if (cnt == '0) state_next = lrj_pkg::S_FINISH;
        else if (cnt[0])        state_next = lrj_pkg::S_J_MX;
        else                    state_next = lrj_pkg::S_J_MB;
      end
      lrj_pkg::S_J_MX:   if (su_done) state_next = lrj_pkg::S_J_MB;
      lrj_pkg::S_J_MB:   if (su_done) state_next = lrj_pkg::S_J_MA;
      lrj_pkg::S_J_MA:   if (su_done) state_next = lrj_pkg::S_J_CHK;
      lrj_pkg::S_FINISH: if (!rsp.valid || rsp.ready) state_next = lrj_pkg::S_IDLE;
      default:           state_next = lrj_pkg::S_IDLE;
    endcase
  end

  // Controller outputs: unit launches and operand selection
  always_comb begin
    su_cmd.start = 1'b0;
    su_cmd.op    = lrj_pkg::SU_DIV;
    su_a         = '0;
    su_b         = '0;
    cnt_start    = 1'b0;
    req.ready    = 1'b0;
    unique case (state)
      lrj_pkg::S_IDLE:  req.ready = 1'b1;
      lrj_pkg::S_SEED: begin
        su_cmd.start = !launched; su_a = seed; su_b = m;
      end
      lrj_pkg::S_COUNT: cnt_start = !launched;
      lrj_pkg::S_RA: begin
        su_cmd.start = !launched; su_a = multiplier; su_b = m;
      end
      lrj_pkg::S_EU_DIV: begin
        su_cmd.start = !launched; su_a = ra; su_b = rb;
      end
      lrj_pkg::S_EU_MUL: begin
        su_cmd.start = !launched; su_cmd.op = lrj_pkg::SU_MUL; su_a = cs; su_b = q;
      end
      lrj_pkg::S_B_RED: begin
        su_cmd.start = !launched; su_a = increment; su_b = m;
      end
      lrj_pkg::S_B_MUL: begin
        su_cmd.start = !launched; su_cmd.op = lrj_pkg::SU_MUL; su_a = q; su_b = cu;
      end
      lrj_pkg::S_X_RED: begin
        su_cmd.start = !launched; su_a = cur; su_b = m;
      end
      lrj_pkg::S_J_MX: begin
        su_cmd.start = !launched; su_cmd.op = lrj_pkg::SU_MUL; su_a = ma; su_b = x;
      end
      lrj_pkg::S_J_MB: begin
        su_cmd.start = !launched; su_cmd.op = lrj_pkg::SU_MUL; su_a = mb; su_b = ma1;
      end
      lrj_pkg::S_J_MA: begin
        su_cmd.start = !launched; su_cmd.op = lrj_pkg::SU_MUL; su_a = ma; su_b = ma;
      end
      default: su_cmd.start = 1'b0;
    endcase
  end

  assign cfg.ready = 1'b1;

  // Control state, registers and response word
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lrj_pkg::S_IDLE;
      launched   <= 1'b0;
      multiplier <= MULT_RST;
      increment  <= '0;
      modulus    <= MOD_RST;
      cur        <= '0;
      inv_ready  <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= (state_next == state) ? (launched | su_cmd.start | cnt_start) : 1'b0;

      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;

      unique case (state)
        lrj_pkg::S_SEED:   if (su_done) cur <= su_rem;
        lrj_pkg::S_B_MUL:  if (su_done) inv_ready <= 1'b1;
        lrj_pkg::S_J_CHK:  if (cnt == '0) cur <= x;
        lrj_pkg::S_FINISH: if (!rsp.valid || rsp.ready) rsp.valid <= 1'b1;
        default: ;
      endcase

      // Register writes; any valid index drops the cached inverse
      if (cfg.valid) begin
        unique case (cfg.index)
          lrj_pkg::REG_MULT: begin multiplier <= cfg.data; inv_ready <= 1'b0; end
          lrj_pkg::REG_INCR: begin increment  <= cfg.data; inv_ready <= 1'b0; end
          lrj_pkg::REG_MOD:  begin modulus    <= cfg.data; inv_ready <= 1'b0; end
          default: ;
        endcase
      end
    end
  end

  // Datapath words
  always_ff @(posedge clk) begin
    unique case (state)
      lrj_pkg::S_IDLE: begin
        if (accept) begin
          rtype <= req.req_type;
          seed  <= req.seed_value;
          sa    <= req.step_a;
          sb    <= req.step_b;
          err   <= 1'b0;
        end
      end
      lrj_pkg::S_COUNT: if (cnt_done) cnt <= product;
      lrj_pkg::S_RA: begin
        if (su_done) begin
          ra <= su_rem;
          rb <= m;
          cu <= (m == W'(1)) ? '0 : W'(1);
          cs <= '0;
        end
      end
      lrj_pkg::S_EU_CHK: if (rb == '0 && ra != W'(1)) err <= 1'b1;
      lrj_pkg::S_EU_DIV: begin
        if (su_done) begin
          q  <= su_quo;
          rr <= su_rem;
        end
      end
      lrj_pkg::S_EU_MUL: begin
        if (su_done) begin
          ra <= rb;
          rb <= rr;
          cu <= cs;
          cs <= cu_sub;
        end
      end
      lrj_pkg::S_B_RED: if (su_done) q <= su_rem;
      lrj_pkg::S_B_MUL: begin
        if (su_done) begin
          ai <= cu;
          bi <= neg_t;
        end
      end
      lrj_pkg::S_X_RED: begin
        if (su_done) begin
          x  <= su_rem;
          ma <= ai;
          mb <= bi;
        end
      end
      lrj_pkg::S_J_MX: if (su_done) x <= x_add;
      lrj_pkg::S_J_MB: if (su_done) mb <= su_rem;
      lrj_pkg::S_J_MA: begin
        if (su_done) begin
          ma  <= su_rem;
          cnt <= cnt >> 1;
        end
      end
      lrj_pkg::S_FINISH: begin
        if (!rsp.valid || rsp.ready) begin
          rsp.state_value  <= cur;
          rsp.rewind_error <= err & rtype;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ src/lrj_serial.sv @@
// Bit-serial arithmetic unit: restoring division and interleaved modular
// multiplication, one bit per cycle. Depends on lrj_pkg.
`default_nettype none

module lrj_serial #(
  parameter int VALUE_WIDTH = 31
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire lrj_pkg::su_cmd_t        cmd,
  input  wire [VALUE_WIDTH-1:0]        opa,   // dividend, or multiplicand (< m)
  input  wire [VALUE_WIDTH-1:0]        opb,   // divisor, or multiplier bits
  input  wire [VALUE_WIDTH-1:0]        modulus,
  output logic                         done,
  output logic [VALUE_WIDTH-1:0]       quo,
  output logic [VALUE_WIDTH-1:0]       rem
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]     acc;
  logic [W-1:0]     sh;
  logic [W-1:0]     dv;
  logic [W-1:0]     xv;
  lrj_pkg::su_op_t  op;
  logic [CW-1:0]    cnt;
  logic             busy;

  logic [W:0] t_div;
  logic [W:0] t_dbl;
  logic [W:0] t_add;
  logic [W-1:0] acc_next;
  logic         qbit;

  // One step of the selected operation
  always_comb begin
    t_div = {acc, sh[W-1]};
    t_dbl = {acc, 1'b0};
    t_add = '0;
    qbit  = 1'b0;
    acc_next = acc;
    unique case (op)
      lrj_pkg::SU_DIV: begin
        if (t_div >= {1'b0, dv}) begin
          acc_next = W'(t_div - {1'b0, dv});
          qbit = 1'b1;
        end else begin
          acc_next = t_div[W-1:0];
        end
      end
      lrj_pkg::SU_MUL: begin
        if (t_dbl >= {1'b0, dv}) begin
          t_dbl = t_dbl - {1'b0, dv};
        end
        t_add = t_dbl;
        if (sh[W-1]) begin
          t_add = t_dbl + {1'b0, xv};
        end
        if (t_add >= {1'b0, dv}) begin
          t_add = t_add - {1'b0, dv};
        end
        acc_next = t_add[W-1:0];
      end
      default: acc_next = acc;
    endcase
  end

  // Load operands on start, then shift one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        op   <= cmd.op;
        acc  <= '0;
        xv   <= opa;
        if (cmd.op == lrj_pkg::SU_DIV) begin
          sh <= opa;
          dv <= opb;
        end else begin
          sh <= opb;
          dv <= modulus;
        end
      end else if (busy) begin
        acc <= acc_next;
        sh  <= {sh[W-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = sh;
  assign rem = acc;

endmodule

`default_nettype wire

@@ src/lrj_count.sv @@
// Bit-serial shift-add multiplier forming the rewind step count a*b.
// Standalone; one bit of the second factor per cycle.
`default_nettype none

module lrj_count #(
  parameter int VALUE_WIDTH = 31
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  input  wire [VALUE_WIDTH-1:0]      fa,
  input  wire [VALUE_WIDTH-1:0]      fb,
  output logic                       done,
  output logic [2*VALUE_WIDTH-1:0]   product
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  hi;
  logic [W-1:0]  lo;
  logic [W-1:0]  av;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    s;

  assign s = {1'b0, hi} + (lo[0] ? {1'b0, av} : '0);

  // Add and shift right one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        hi   <= '0;
        lo   <= fb;
        av   <= fa;
      end else if (busy) begin
        hi  <= s[W:1];
        lo  <= {s[0], lo[W-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = {hi, lo};

endmodule

`default_nettype wire

@@ verif/tb_lrj_sb.sv @@
// Scoreboard for the LCG rewind/jump testbench: predicts generator state.
// Depends on lrj_pkg for request and register codes.
`timescale 1ns / 100ps

class lrj_state_sb;
  bit [30:0] mult_reg, incr_reg, mod_reg;
  bit [30:0] cur_state, inv_mult, inv_incr;
  bit        inv_valid;
  bit [30:0] exp_state[$];
  bit        exp_err[$];
  int        mismatches;
  int        checked;

  function void reset_state();
    mult_reg = 31'd16807; incr_reg = 0; mod_reg = 31'h7fffffff;
    cur_state = 0; inv_mult = 0; inv_incr = 0; inv_valid = 0;
    exp_state.delete(); exp_err.delete();
  endfunction

  function void write_reg(bit [1:0] idx, bit [30:0] val);
    if (idx == lrj_pkg::REG_MULT) mult_reg = val;
    else if (idx == lrj_pkg::REG_INCR) incr_reg = val;
    else if (idx == lrj_pkg::REG_MOD) mod_reg = val;
    else return;
    inv_valid = 0;
  endfunction

  // Extended Euclid; returns 0 when the multiplier has no inverse
  function bit derive_inv(longint unsigned m);
    longint ra, rb, cu, cs, q, r, n;
    longint unsigned bm;
    ra = longint'(mult_reg % m); rb = longint'(m); cu = 1; cs = 0;
    if (m == 1) begin
      inv_mult = 0; inv_incr = 0; inv_valid = 1;
      return 1;
    end
    while (rb != 0) begin
      q = ra / rb; r = ra - q * rb; n = cu - q * cs;
      ra = rb; rb = r; cu = cs; cs = n;
    end
    if (ra != 1) return 0;
    cu = cu % longint'(m);
    if (cu < 0) cu += longint'(m);
    bm = incr_reg % m;
    inv_mult = 31'(cu);
    inv_incr = 31'((m - (bm * longint'(cu)) % m) % m);
    inv_valid = 1;
    return 1;
  endfunction

  // Note an accepted request and queue the state it leads to
  function void note_request(bit rtype, bit [30:0] seed, bit [30:0] sa, bit [30:0] sb);
    longint unsigned m, cnt, x, ma, mb;
    bit err;
    m = (mod_reg == 0) ? 1 : mod_reg;
    err = 0;
    if (rtype == lrj_pkg::REQ_LOAD) begin
      cur_state = 31'(seed % m);
    end else begin
      cnt = longint'(sa) * longint'(sb);
      if (!inv_valid && !derive_inv(m)) err = 1;
      else begin
        x = cur_state % m; ma = inv_mult % m; mb = inv_incr % m;
        while (cnt != 0) begin
          if (cnt[0]) x = (ma * x + mb) % m;
          mb = (((ma + 1) % m) * mb) % m;
          ma = (ma * ma) % m;
          cnt >>= 1;
        end
        cur_state = 31'(x);
      end
    end
    exp_state.push_back(cur_state);
    exp_err.push_back(err);
  endfunction

  function void check_response(bit [30:0] st, bit er);
    bit [30:0] es;
    bit ee;
    checked++;
    if (exp_state.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected response state=%0d err=%0b", st, er);
      return;
    end
    es = exp_state.pop_front(); ee = exp_err.pop_front();
    if (es != st || ee != er) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: state exp %0d got %0d, error exp %0b got %0b", es, st, ee, er);
    end
  endfunction
endclass

@@ verif/tb_top.sv @@
// Top of the LCG rewind/jump testbench: clock, reset, drivers and checking.
// Depends on lrj_pkg, lrj_if, lcg_rewind_jump and tb_lrj_sb.
`timescale 1ns / 100ps

module tb_top;

  // Register index outside the list; a write to it must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk, rst;
  lrj_req_if req_ch();
  lrj_rsp_if rsp_ch();
  lrj_cfg_if cfg_ch();

  lcg_rewind_jump dut (.clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source),
                       .cfg(cfg_ch.sink));

  lrj_state_sb sb;
  int idle_pct, stall_pct;
  bit hold_rsp;
  longint cycles = 0;
  int n_loads, n_rewinds, n_errs;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // Watchdog: ends the run as failed if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd40000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Response side: random stall, check on accept
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (rsp_ch.rewind_error) n_errs++;
      sb.check_response(rsp_ch.state_value, rsp_ch.rewind_error);
    end
  end
  always @(negedge clk)
    rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= stall_pct);

  // Offer one word; valid stays up for a following word, wait_drain drops it
  task automatic send_req(bit rtype, bit [30:0] seed, bit [30:0] sa, bit [30:0] sb_v);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 0;
      @(negedge clk);
    end
    req_ch.valid <= 1; req_ch.req_type <= rtype;
    req_ch.seed_value <= seed; req_ch.step_a <= sa; req_ch.step_b <= sb_v;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(rtype, seed, sa, sb_v);
    if (rtype == lrj_pkg::REQ_LOAD) n_loads++; else n_rewinds++;
    @(negedge clk);
  endtask

  // Drop valid, drain, then let the block settle before touching registers
  task automatic wait_drain();
    req_ch.valid <= 0;
    while (sb.exp_state.size() != 0) @(negedge clk);
    repeat (8000) @(negedge clk);
  endtask

  task automatic write_cfg(bit [1:0] idx, bit [30:0] val);
    cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 0;
    @(negedge clk);
  endtask

  function automatic bit [30:0] rand_val();
    case ($urandom_range(5))
      0: return 0;
      1: return 31'h7fffffff;
      2: return 31'($urandom_range(15));
      default: return 31'($urandom);
    endcase
  endfunction

  // Random counts lean small: the rewind time grows with count bits
  function automatic bit [30:0] rand_step();
    case ($urandom_range(7))
      0: return 31'($urandom);
      1: return 31'h7fffffff;
      default: return 31'($urandom_range(300));
    endcase
  endfunction

  task automatic rand_phase(int n);
    repeat (n) begin
      if ($urandom_range(2) == 0)
        send_req(lrj_pkg::REQ_LOAD, rand_val(), rand_step(), rand_step());
      else
        send_req(lrj_pkg::REQ_REWIND, rand_val(), rand_step(), rand_step());
    end
  endtask

  initial begin
    bit [30:0] mods[6];
    sb = new();
    sb.reset_state();
    idle_pct = 0; stall_pct = 0; hold_rsp = 0;
    rst = 1;
    req_ch.valid = 0; req_ch.req_type = lrj_pkg::REQ_LOAD; req_ch.seed_value = 0;
    req_ch.step_a = 0; req_ch.step_b = 0;
    cfg_ch.valid = 0; cfg_ch.index = lrj_pkg::REG_MULT; cfg_ch.data = 0;
    rsp_ch.ready = 0;
    repeat (12) @(negedge clk);
    rst = 0;

    // Directed: reset registers, field extremes, zero count, big counts
    send_req(lrj_pkg::REQ_REWIND, 0, 5, 7);
    send_req(lrj_pkg::REQ_LOAD, 31'h7fffffff, 0, 0);
    send_req(lrj_pkg::REQ_LOAD, 31'h7ffffffe, 0, 0);
    send_req(lrj_pkg::REQ_REWIND, 0, 0, 31'h7fffffff);
    send_req(lrj_pkg::REQ_REWIND, 0, 31'h7fffffff, 31'h7fffffff);
    send_req(lrj_pkg::REQ_LOAD, 12345, 31'h7fffffff, 31'h7fffffff);
    send_req(lrj_pkg::REQ_REWIND, 31'h7fffffff, 1, 1);
    wait_drain();
    write_cfg(lrj_pkg::REG_INCR, 31'h7fffffff);
    write_cfg(lrj_pkg::REG_MULT, 0);
    send_req(lrj_pkg::REQ_REWIND, 0, 3, 3);           // zero multiplier refused
    wait_drain();
    write_cfg(lrj_pkg::REG_MULT, 31'h7fffffff);       // multiplier equal to modulus
    send_req(lrj_pkg::REQ_REWIND, 0, 3, 3);
    wait_drain();
    write_cfg(lrj_pkg::REG_MOD, 1);                   // modulus one
    send_req(lrj_pkg::REQ_REWIND, 0, 9, 9);
    send_req(lrj_pkg::REQ_LOAD, 77, 0, 0);
    wait_drain();
    write_cfg(lrj_pkg::REG_MOD, 0);                   // modulus zero
    send_req(lrj_pkg::REQ_REWIND, 0, 2, 2);
    wait_drain();
    write_cfg(lrj_pkg::REG_MOD, 1000); write_cfg(lrj_pkg::REG_MULT, 21);
    send_req(lrj_pkg::REQ_LOAD, 999, 0, 0);
    wait_drain();
    write_cfg(lrj_pkg::REG_MOD, 10);                  // state above new modulus
    send_req(lrj_pkg::REQ_REWIND, 0, 0, 0);
    wait_drain();
    write_cfg(lrj_pkg::REG_MULT, 4);
    send_req(lrj_pkg::REQ_LOAD, 555, 0, 0);
    wait_drain();
    write_cfg(lrj_pkg::REG_MOD, 1000);
    send_req(lrj_pkg::REQ_REWIND, 0, 1, 1);           // gcd>1 refused, echoes state
    wait_drain();
    write_cfg(REG_UNUSED, 5);                         // unlisted index ignored

    // Random phases across settings and idling modes
    mods = '{31'h7fffffff, 2, 31'h7ffffffe, 97, 65536, 31'($urandom)};
    for (int ph = 0; ph < 8; ph++) begin
      wait_drain();
      write_cfg(lrj_pkg::REG_MOD, (ph < 6) ? mods[ph] : rand_val());
      write_cfg(lrj_pkg::REG_MULT,
                ($urandom_range(3) == 0) ? rand_val() : 31'($urandom) | 31'd1);
      write_cfg(lrj_pkg::REG_INCR, rand_val());
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      if (ph == 2) begin
        fork
          begin
            hold_rsp = 1;
            repeat (3000) @(negedge clk);
            hold_rsp = 0;
          end
          rand_phase(20);
        join
      end
      rand_phase(230);
    end

    wait_drain();
    $display("Covered %0d loads and %0d rewinds (%0d refused) across directed and random register settings",
             n_loads, n_rewinds, n_errs);
    $display("Responses checked: %0d, mismatches: %0d", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.exp_state.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
